>>> design/mpsm_pkg.sv
// Package with shared constants for the multi-pattern string matcher.
`default_nettype none
package mpsm_pkg;
  localparam int NODE_W        = 8;
  localparam int CHAR_W        = 5;
  localparam int GOTO_AW       = NODE_W + CHAR_W;
  localparam int MAX_PATTERNS  = 16;
  localparam int PID_W         = 4;
  localparam int PCNT_W        = 5;
  localparam int NCNT_W        = 9;
  localparam int IDX_W         = 16;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_NODES     = 256;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_PAT   = 2'd1;
  localparam logic [1:0] FUNC_BUILD = 2'd2;
  localparam logic [1:0] FUNC_TEXT  = 2'd3;

  localparam logic [1:0] KIND_MATCH    = 2'd0;
  localparam logic [1:0] KIND_BUILD_OK = 2'd1;
  localparam logic [1:0] KIND_NODE_OVF = 2'd2;
  localparam logic [1:0] KIND_PAT_OVF  = 2'd3;

  typedef logic [NODE_W-1:0] node_t;
endpackage
`default_nettype wire

>>> design/multi_pattern_string_matcher.sv
// Aho-Corasick matcher: trie insertion, breadth-first build and text scan over RAM tables.
// A pattern letter reads its goto entry and then writes back; a text letter follows failure
//   links on the fall-back walk, then walks the output chain and reports each match.
// Items are handled one at a time; a build scans the root's goto entries, then dequeues nodes
//   breadth-first, scanning each node's children and following failure links.
// Reset and a clear item both start a clearing pass over the 8192-entry goto RAM
//   during which no item is taken.
`default_nettype none
module multi_pattern_string_matcher (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [4:0] char_code, rest zero
  input  wire  [2:0]  s_tuser,   // [1:0] func, [2] text_start
  input  wire         s_tlast,   // pattern_end
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [3:0] pattern_id, [19:4] end_index, rest zero
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast    // last_of_run
);
  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_P_RD   = 5'd2;
  localparam logic [4:0] S_P_WB   = 5'd3;
  localparam logic [4:0] S_B_RRD  = 5'd4;
  localparam logic [4:0] S_B_RCHK = 5'd5;
  localparam logic [4:0] S_B_DEQ  = 5'd6;
  localparam logic [4:0] S_B_DEQW = 5'd7;
  localparam logic [4:0] S_B_FN   = 5'd8;
  localparam logic [4:0] S_B_CRD  = 5'd9;
  localparam logic [4:0] S_B_CCHK = 5'd10;
  localparam logic [4:0] S_B_WRD  = 5'd11;
  localparam logic [4:0] S_B_WCHK = 5'd12;
  localparam logic [4:0] S_B_WF   = 5'd13;
  localparam logic [4:0] S_B_DONE = 5'd14;
  localparam logic [4:0] S_T_RD   = 5'd15;
  localparam logic [4:0] S_T_CHK  = 5'd16;
  localparam logic [4:0] S_T_F    = 5'd17;
  localparam logic [4:0] S_T_MATCH = 5'd18;
  localparam logic [4:0] S_T_NF   = 5'd19;
  localparam logic [4:0] S_T_END  = 5'd20;

  localparam logic [mpsm_pkg::CHAR_W-1:0] LAST_CH =
    mpsm_pkg::CHAR_W'(mpsm_pkg::ALPHABET_SIZE - 1);

  logic [4:0] state;
  logic [mpsm_pkg::GOTO_AW-1:0] clr_addr;
  logic [mpsm_pkg::CHAR_W-1:0] cur_ch;
  logic cur_pend;

  logic [mpsm_pkg::NCNT_W-1:0] node_count;
  logic [mpsm_pkg::PCNT_W-1:0] pat_count;
  mpsm_pkg::node_t cursor, scan_node;
  logic drop_pending, built, node_ovf, pat_ovf;
  logic [mpsm_pkg::IDX_W-1:0] text_pos, idx;
  mpsm_pkg::node_t pend_node [mpsm_pkg::MAX_PATTERNS];

  mpsm_pkg::node_t head, tail, bn, bfn, bu, bv;
  logic [mpsm_pkg::CHAR_W-1:0] bc;
  logic [mpsm_pkg::MAX_PATTERNS-1:0] mask;
  logic [mpsm_pkg::PCNT_W-1:0] res_cnt;
  logic hold_valid;
  logic [mpsm_pkg::PID_W-1:0] hold_id;

  // Goto RAM: entry {node, letter} holds the child, zero meaning absent (root is never a child).
  mpsm_pkg::node_t goto_mem [2**mpsm_pkg::GOTO_AW];
  logic goto_we;
  logic [mpsm_pkg::GOTO_AW-1:0] goto_wa, goto_ra;
  mpsm_pkg::node_t goto_wd, goto_rd;

  mpsm_pkg::node_t fail_mem [mpsm_pkg::MAX_NODES];
  logic fail_we;
  mpsm_pkg::node_t fail_wa, fail_wd, fail_ra, fail_rd;

  mpsm_pkg::node_t queue_mem [mpsm_pkg::MAX_NODES];
  logic queue_we;
  mpsm_pkg::node_t queue_wa, queue_wd, queue_rd;

  always_ff @(posedge clk) begin
    if (goto_we) begin
      goto_mem[goto_wa] <= goto_wd;
    end
    goto_rd <= goto_mem[goto_ra];
  end

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[queue_wa] <= queue_wd;
    end
    queue_rd <= queue_mem[head];
  end

  logic accept, clear_go, out_free, ch_ok, walk_back, emit;
  logic [1:0] in_func;
  logic [mpsm_pkg::CHAR_W-1:0] in_ch;
  logic [mpsm_pkg::PID_W-1:0] low_id;
  mpsm_pkg::node_t mask_src;
  logic [mpsm_pkg::MAX_PATTERNS-1:0] mask_new;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_func  = s_tuser[1:0];
  assign in_ch    = s_tdata[mpsm_pkg::CHAR_W-1:0];
  assign ch_ok    = (in_ch < mpsm_pkg::CHAR_W'(mpsm_pkg::ALPHABET_SIZE));
  assign clear_go = accept && (in_func == mpsm_pkg::FUNC_CLEAR);
  assign out_free = !m_tvalid || m_tready;
  // Keep following failure links while the current node is not the root and has no edge for this letter.
  assign walk_back = (bv != '0) && (goto_rd == '0);

  always_comb begin
    mask_src = (state == S_T_NF) ? fail_rd : goto_rd;
    for (int k = 0; k < mpsm_pkg::MAX_PATTERNS; k++) begin
      mask_new[k] = (mpsm_pkg::PCNT_W'(k) < pat_count) && (pend_node[k] == mask_src);
    end
    low_id = '0;
    for (int k = mpsm_pkg::MAX_PATTERNS - 1; k >= 0; k--) begin
      if (mask[k]) begin
        low_id = mpsm_pkg::PID_W'(k);
      end
    end
  end

  // A new result item is loaded into the output register in these cases.
  always_comb begin
    case (state)
      S_B_DONE: emit = out_free;
      S_T_MATCH: begin
        emit = (res_cnt != mpsm_pkg::PCNT_W'(mpsm_pkg::MAX_PATTERNS)) && (mask != '0) &&
               hold_valid && out_free;
      end
      S_T_END: emit = hold_valid && out_free;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    goto_we = 1'b0;
    goto_wa = {cursor, cur_ch};
    goto_wd = node_count[mpsm_pkg::NODE_W-1:0];
    goto_ra = '0;
    fail_we = 1'b0;
    fail_wa = bu;
    fail_wd = goto_rd;
    fail_ra = bv;
    queue_we = 1'b0;
    queue_wa = tail;
    queue_wd = bu;
    case (state)
      S_CLEAR: begin
        goto_we = 1'b1;
        goto_wa = clr_addr;
        goto_wd = '0;
      end
      S_P_RD: goto_ra = {cursor, cur_ch};
      S_P_WB: begin
        goto_we = !drop_pending && (goto_rd == '0) &&
                  (node_count < mpsm_pkg::NCNT_W'(mpsm_pkg::MAX_NODES));
      end
      S_B_RRD: goto_ra = {mpsm_pkg::NODE_W'(0), bc};
      S_B_RCHK: begin
        fail_we  = (goto_rd != '0);
        fail_wa  = goto_rd;
        fail_wd  = '0;
        queue_we = (goto_rd != '0);
        queue_wd = goto_rd;
      end
      S_B_DEQW: fail_ra = queue_rd;
      S_B_CRD:  goto_ra = {bn, bc};
      S_B_WRD:  goto_ra = {bv, bc};
      S_B_WCHK: begin
        fail_we  = !walk_back;
        queue_we = !walk_back;
      end
      S_T_RD: goto_ra = {bv, cur_ch};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear_go) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      node_count   <= mpsm_pkg::NCNT_W'(1);
      pat_count    <= '0;
      cursor       <= '0;
      drop_pending <= 1'b0;
      scan_node    <= '0;
      text_pos     <= '0;
      built        <= 1'b0;
      node_ovf     <= 1'b0;
      pat_ovf      <= 1'b0;
      hold_valid   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_ch   <= in_ch;
            cur_pend <= s_tlast;
            if (in_func == mpsm_pkg::FUNC_BUILD) begin
              head  <= '0;
              tail  <= '0;
              bc    <= '0;
              state <= S_B_RRD;
            end else if (in_func == mpsm_pkg::FUNC_PAT && ch_ok) begin
              built <= 1'b0;
              state <= S_P_RD;
            end else if (in_func == mpsm_pkg::FUNC_TEXT && ch_ok && built) begin
              bv       <= s_tuser[2] ? '0 : scan_node;
              idx      <= s_tuser[2] ? '0 : text_pos;
              text_pos <= s_tuser[2] ? mpsm_pkg::IDX_W'(1) :
                          (text_pos == '1) ? text_pos : text_pos + 1'b1;
              res_cnt  <= '0;
              state    <= S_T_RD;
            end
          end
        end
        S_P_RD: state <= S_P_WB;
        S_P_WB: begin
          logic drop_n;
          mpsm_pkg::node_t cur_n;
          drop_n = drop_pending;
          cur_n  = cursor;
          if (!drop_pending) begin
            if (goto_rd != '0) begin
              cur_n = goto_rd;
            end else if (node_count < mpsm_pkg::NCNT_W'(mpsm_pkg::MAX_NODES)) begin
              cur_n      = node_count[mpsm_pkg::NODE_W-1:0];
              node_count <= node_count + 1'b1;
            end else begin
              drop_n   = 1'b1;
              node_ovf <= 1'b1;
            end
          end
          if (cur_pend) begin
            if (!drop_n) begin
              if (pat_count < mpsm_pkg::PCNT_W'(mpsm_pkg::MAX_PATTERNS)) begin
                pend_node[pat_count[mpsm_pkg::PID_W-1:0]] <= cur_n;
                pat_count <= pat_count + 1'b1;
              end else begin
                pat_ovf <= 1'b1;
              end
            end
            cursor       <= '0;
            drop_pending <= 1'b0;
          end else begin
            cursor       <= cur_n;
            drop_pending <= drop_n;
          end
          state <= S_IDLE;
        end
        S_B_RRD: state <= S_B_RCHK;
        S_B_RCHK: begin
          if (goto_rd != '0) begin
            tail <= tail + 1'b1;
          end
          if (bc == LAST_CH) begin
            state <= S_B_DEQ;
          end else begin
            bc    <= bc + 1'b1;
            state <= S_B_RRD;
          end
        end
        S_B_DEQ: begin
          if (head == tail) begin
            state <= S_B_DONE;
          end else begin
            state <= S_B_DEQW;
          end
        end
        S_B_DEQW: begin
          bn    <= queue_rd;
          head  <= head + 1'b1;
          state <= S_B_FN;
        end
        S_B_FN: begin
          bfn   <= fail_rd;
          bc    <= '0;
          state <= S_B_CRD;
        end
        S_B_CRD: state <= S_B_CCHK;
        S_B_CCHK: begin
          if (goto_rd != '0) begin
            bu    <= goto_rd;
            bv    <= bfn;
            state <= S_B_WRD;
          end else if (bc == LAST_CH) begin
            state <= S_B_DEQ;
          end else begin
            bc    <= bc + 1'b1;
            state <= S_B_CRD;
          end
        end
        S_B_WRD: state <= S_B_WCHK;
        S_B_WCHK: begin
          if (walk_back) begin
            state <= S_B_WF;
          end else begin
            tail <= tail + 1'b1;
            if (bc == LAST_CH) begin
              state <= S_B_DEQ;
            end else begin
              bc    <= bc + 1'b1;
              state <= S_B_CRD;
            end
          end
        end
        S_B_WF: begin
          bv    <= fail_rd;
          state <= S_B_WRD;
        end
        S_B_DONE: begin
          if (out_free) begin
            m_tuser   <= node_ovf ? mpsm_pkg::KIND_NODE_OVF :
                         pat_ovf  ? mpsm_pkg::KIND_PAT_OVF : mpsm_pkg::KIND_BUILD_OK;
            m_tdata   <= '0;
            m_tlast   <= 1'b1;
            built     <= 1'b1;
            scan_node <= '0;
            text_pos  <= '0;
            state     <= S_IDLE;
          end
        end
        S_T_RD: state <= S_T_CHK;
        S_T_CHK: begin
          if (walk_back) begin
            state <= S_T_F;
          end else begin
            scan_node <= goto_rd;
            bv        <= goto_rd;
            mask      <= mask_new;
            state     <= (goto_rd == '0) ? S_T_END : S_T_MATCH;
          end
        end
        S_T_F: begin
          bv    <= fail_rd;
          state <= S_T_RD;
        end
        S_T_MATCH: begin
          if (res_cnt == mpsm_pkg::PCNT_W'(mpsm_pkg::MAX_PATTERNS)) begin
            state <= S_T_END;
          end else if (mask == '0) begin
            state <= S_T_NF;
          end else if (!hold_valid || out_free) begin
            // The held match goes out only once a later one proves it is not the last.
            if (hold_valid) begin
              m_tuser  <= mpsm_pkg::KIND_MATCH;
              m_tdata  <= {4'd0, idx, hold_id};
              m_tlast  <= 1'b0;
            end
            hold_valid    <= 1'b1;
            hold_id       <= low_id;
            mask[low_id]  <= 1'b0;
            res_cnt       <= res_cnt + 1'b1;
          end
        end
        S_T_NF: begin
          bv    <= fail_rd;
          mask  <= mask_new;
          state <= (fail_rd == '0) ? S_T_END : S_T_MATCH;
        end
        S_T_END: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tuser    <= mpsm_pkg::KIND_MATCH;
            m_tdata    <= {4'd0, idx, hold_id};
            m_tlast    <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
